// ===== rtl/core/brb_pkg.sv =====
`default_nettype none
package brb_pkg;

   localparam int DEPTH     = 1024;
   localparam int MAX_CHUNK = 8;

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int SZ_W   = 11;
   localparam int CNT_W  = 4;
   localparam int OP_W   = 2;
   localparam int DATA_W = 64;
   localparam int LVL_W  = 10;
   localparam int SLOT_W = 3;
   localparam int IDX_W  = 1;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;
   localparam logic [OP_W-1:0] OP_SKIP  = 2'd3;

   localparam logic [IDX_W-1:0] REG_SIZE   = 1'd0;
   localparam logic [IDX_W-1:0] REG_ENABLE = 1'd1;

   typedef struct packed {
      logic [SZ_W-1:0] size;
      logic            enabled;
      logic            clear;
   } cfg_type;

   typedef struct packed {
      logic             we;
      logic [PTR_W-1:0] waddr;
      logic [7:0]       wdata;
      logic [PTR_W-1:0] raddr;
   } ram_req_type;

   // ptr + inc, wrapped at size; inc is always below size when used
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [CNT_W-1:0] inc,
                                                  input logic [SZ_W-1:0]  size);
      logic [SZ_W:0] s;
      s = {1'b0, SZ_W'(ptr)} + (SZ_W + 1)'(inc);
      if (s >= {1'b0, size}) begin
         s = s - {1'b0, size};
      end
      return PTR_W'(s);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/brb_ram.sv =====
`default_nettype none
module brb_ram (
   input  wire logic               clock,
   input  wire brb_pkg::ram_req_type req,
   output logic [7:0]              rd_data
);

   logic [7:0] mem [brb_pkg::DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      rdata_ff <= mem[req.raddr];
   end

   assign rd_data = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/core/brb_ctrl.sv =====
`default_nettype none
module brb_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire brb_pkg::cfg_type             cfg,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [brb_pkg::OP_W-1:0]     req_op,
   input  wire logic [brb_pkg::CNT_W-1:0]    req_count,
   input  wire logic [brb_pkg::DATA_W-1:0]   req_write_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_ok,
   output logic [brb_pkg::DATA_W-1:0]        rsp_read_data,
   output logic [brb_pkg::LVL_W-1:0]         rsp_fill_level,
   output logic [brb_pkg::LVL_W-1:0]         rsp_free_space,
   output brb_pkg::ram_req_type              ram_req,
   input  wire logic [7:0]                   ram_rd_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WRITE = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [brb_pkg::OP_W-1:0]      op_ff, op_in;
   logic [brb_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [brb_pkg::DATA_W-1:0]    wdata_ff, wdata_in;
   logic                          ok_ff, ok_in;
   logic [brb_pkg::PTR_W-1:0]     fill_ff, fill_in;
   logic [brb_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                          rd_pend_ff, rd_pend_in;
   logic [brb_pkg::SLOT_W-1:0]    rd_slot_ff, rd_slot_in;
   logic [brb_pkg::DATA_W-1:0]    rdata_ff, rdata_in;
   logic [brb_pkg::PTR_W-1:0]     wp_ff, wp_in;
   logic [brb_pkg::PTR_W-1:0]     rp_ff, rp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_ok_ff, rsp_ok_in;
   logic [brb_pkg::DATA_W-1:0]    rsp_rdata_ff, rsp_rdata_in;
   logic [brb_pkg::LVL_W-1:0]     rsp_fill_ff, rsp_fill_in;
   logic [brb_pkg::LVL_W-1:0]     rsp_space_ff, rsp_space_in;

   logic [brb_pkg::PTR_W-1:0]     fill_now;
   logic [brb_pkg::PTR_W-1:0]     space_now;
   logic [brb_pkg::PTR_W-1:0]     count_ext;
   logic                          decide_ok;
   logic                          accept;
   logic                          out_free;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign count_ext = brb_pkg::PTR_W'(req_count);

   // levels before the item, from the current pointers
   always_comb begin
      if (wp_ff >= rp_ff) begin
         fill_now = wp_ff - rp_ff;
      end else begin
         fill_now = brb_pkg::PTR_W'(brb_pkg::SZ_W'(wp_ff) + cfg.size - brb_pkg::SZ_W'(rp_ff));
      end
      space_now = brb_pkg::PTR_W'(cfg.size - brb_pkg::SZ_W'(1) - brb_pkg::SZ_W'(fill_now));
      decide_ok = 1'b0;
      if (req_count <= brb_pkg::CNT_W'(brb_pkg::MAX_CHUNK)) begin
         if (req_op == brb_pkg::OP_WRITE) begin
            decide_ok = cfg.enabled && (space_now >= count_ext);
         end else begin
            decide_ok = fill_now >= count_ext;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      wdata_in     = wdata_ff;
      ok_in        = ok_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      rd_pend_in   = 1'b0;
      rd_slot_in   = rd_slot_ff;
      rdata_in     = rdata_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_rdata_in = rsp_rdata_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_space_in = rsp_space_ff;
      ram_req.we    = 1'b0;
      ram_req.waddr = brb_pkg::wrap_add(wp_ff, cnt_ff, cfg.size);
      ram_req.wdata = wdata_ff[{cnt_ff[brb_pkg::SLOT_W-1:0], 3'b000} +: 8];
      ram_req.raddr = brb_pkg::wrap_add(rp_ff, cnt_ff, cfg.size);

      if (rd_pend_ff) begin
         rdata_in[{rd_slot_ff, 3'b000} +: 8] = ram_rd_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               count_in = req_count;
               wdata_in = req_write_data;
               ok_in    = decide_ok;
               cnt_in   = '0;
               rdata_in = '0;
               fill_in  = fill_now;
               state_in = ST_FIN;
               if (decide_ok) begin
                  if (req_op == brb_pkg::OP_WRITE) begin
                     fill_in = fill_now + count_ext;
                  end else if (req_op != brb_pkg::OP_PEEK) begin
                     fill_in = fill_now - count_ext;
                  end
                  if (req_count != '0) begin
                     if (req_op == brb_pkg::OP_WRITE) begin
                        state_in = ST_WRITE;
                     end else if (req_op != brb_pkg::OP_SKIP) begin
                        state_in = ST_READ;
                     end
                  end
               end
            end
         end
         ST_WRITE: begin
            ram_req.we = 1'b1;
            cnt_in     = cnt_ff + brb_pkg::CNT_W'(1);
            if (cnt_in == count_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_READ: begin
            if (cnt_ff != count_ff) begin
               rd_pend_in = 1'b1;
               rd_slot_in = cnt_ff[brb_pkg::SLOT_W-1:0];
               cnt_in     = cnt_ff + brb_pkg::CNT_W'(1);
            end else if (!rd_pend_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_rdata_in = rdata_ff;
               rsp_fill_in  = brb_pkg::LVL_W'(fill_ff);
               rsp_space_in = brb_pkg::LVL_W'(cfg.size - brb_pkg::SZ_W'(1)
                                              - brb_pkg::SZ_W'(fill_ff));
               if (ok_ff) begin
                  if (op_ff == brb_pkg::OP_WRITE) begin
                     wp_in = brb_pkg::wrap_add(wp_ff, count_ff, cfg.size);
                  end else if (op_ff != brb_pkg::OP_PEEK) begin
                     rp_in = brb_pkg::wrap_add(rp_ff, count_ff, cfg.size);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg.clear) begin
         wp_in = '0;
         rp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      count_ff     <= count_in;
      wdata_ff     <= wdata_in;
      ok_ff        <= ok_in;
      fill_ff      <= fill_in;
      cnt_ff       <= cnt_in;
      rd_slot_ff   <= rd_slot_in;
      rdata_ff     <= rdata_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_space_ff <= rsp_space_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_data  = rsp_rdata_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign rsp_free_space = rsp_space_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start");

   a_busy_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE || state_ff == ST_READ) |-> (ok_ff && count_ff != '0))
      else $error("store access for refused or empty item");

   a_write_only_in_write: assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> (state_ff == ST_WRITE))
      else $error("store written outside write phase");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN))
      else $error("result raised outside final state");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/byte_ring_buffer_chunked_core.sv =====
`default_nettype none
// Chunked circular byte FIFO. Each item moves 0 to 8 bytes at once (write, read,
// peek or skip) or nothing, and yields one result with ok, the data and the
// fill and free levels after the operation. Items are handled one at a time;
// the byte store is a single 1024 x 8 RAM with one write and one registered
// read port, so a chunk is moved one byte per cycle; a skip, an empty chunk or
// a refused item moves no bytes and goes straight to the result. The next
// item is accepted while the previous result waits in the output register.
// Writing the size register empties the FIFO; configuration must only be
// written while the block is idle.
module byte_ring_buffer_chunked_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [brb_pkg::IDX_W-1:0]    csr_index,
   input  wire logic [brb_pkg::SZ_W-1:0]     csr_wdata,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [brb_pkg::OP_W-1:0]     req_op,
   input  wire logic [brb_pkg::CNT_W-1:0]    req_count,
   input  wire logic [brb_pkg::DATA_W-1:0]   req_write_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_ok,
   output logic [brb_pkg::DATA_W-1:0]        rsp_read_data,
   output logic [brb_pkg::LVL_W-1:0]         rsp_fill_level,
   output logic [brb_pkg::LVL_W-1:0]         rsp_free_space
);

   logic [brb_pkg::SZ_W-1:0] size_ff, size_in;
   logic                     enabled_ff, enabled_in;
   brb_pkg::cfg_type         cfg;
   brb_pkg::ram_req_type     ram_req;
   logic [7:0]               ram_rd_data;

   always_comb begin
      size_in    = size_ff;
      enabled_in = enabled_ff;
      if (csr_we && csr_index == brb_pkg::REG_SIZE) begin
         size_in = csr_wdata;
      end
      if (csr_we && csr_index == brb_pkg::REG_ENABLE) begin
         enabled_in = csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= brb_pkg::SZ_W'(brb_pkg::DEPTH);
         enabled_ff <= 1'b1;
      end else begin
         size_ff    <= size_in;
         enabled_ff <= enabled_in;
      end
   end

   // size 0 behaves as 1, anything above the store depth as the depth
   always_comb begin
      if (size_ff == '0) begin
         cfg.size = brb_pkg::SZ_W'(1);
      end else if (size_ff > brb_pkg::SZ_W'(brb_pkg::DEPTH)) begin
         cfg.size = brb_pkg::SZ_W'(brb_pkg::DEPTH);
      end else begin
         cfg.size = size_ff;
      end
      cfg.enabled = enabled_ff;
      cfg.clear   = csr_we && (csr_index == brb_pkg::REG_SIZE);
   end

   brb_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_count      (req_count),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_read_data  (rsp_read_data),
      .rsp_fill_level (rsp_fill_level),
      .rsp_free_space (rsp_free_space),
      .ram_req        (ram_req),
      .ram_rd_data    (ram_rd_data)
   );

   brb_ram u_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire
